### hdl/float_to_pcm_sample_converter_core_assert.svh
// Assertion macros for the float-to-PCM converter.
`ifndef FLOAT_TO_PCM_SAMPLE_CONVERTER_CORE_ASSERT_SVH
`define FLOAT_TO_PCM_SAMPLE_CONVERTER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define F2P_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define F2P_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define F2P_ASSERT(label, clk, rst_n, prop, msg)
`define F2P_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

### hdl/f2p_pkg.sv
package f2p_pkg;
  localparam int unsigned SampleWidth = 32;
  localparam int unsigned FmtWidth = 3;
  localparam int unsigned ChanCountWidth = 4;
  localparam int unsigned FramesWidth = 14;
  localparam int unsigned FrameCntWidth = 13;
  localparam int unsigned ChanIdxWidth = 3;
  localparam int unsigned ByteCntWidth = 3;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned DefaultMaxChannels = 8;
  localparam logic [FramesWidth-1:0] FrameLimit = 14'd8192;
  localparam logic [7:0] ExpAllOnes = 8'hFF;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_CHANNEL_COUNT   = 2'd0,
    CFG_CHANNEL_FORMATS = 2'd1,
    CFG_BUFFER_FRAMES   = 2'd2
  } cfg_idx_e;

  typedef enum logic [FmtWidth-1:0] {
    FMT_FLOAT32 = 3'd0,
    FMT_INT32   = 3'd1,
    FMT_INT16   = 3'd2,
    FMT_INT24P  = 3'd3,
    FMT_INT16S  = 3'd4,
    FMT_INT18S  = 3'd5,
    FMT_INT20S  = 3'd6,
    FMT_INT24S  = 3'd7
  } fmt_e;

  typedef struct packed {
    logic [SampleWidth-1:0]  sample_word;
    logic [ByteCntWidth-1:0] byte_count;
    logic [ChanIdxWidth-1:0] channel_index;
    logic                    last_of_frame;
    logic                    last_of_buffer;
  } result_t;

  typedef struct packed {
    logic [ChanIdxWidth-1:0] channel_index;
    logic                    last_of_frame;
    logic                    last_of_buffer;
  } pos_t;

  function automatic logic [31:0] scale_of(input logic [FmtWidth-1:0] fmt);
    case (fmt)
      FMT_INT32:               scale_of = 32'd2147483647;
      FMT_INT16, FMT_INT16S:   scale_of = 32'd32767;
      FMT_INT24P, FMT_INT24S:  scale_of = 32'd8388607;
      FMT_INT18S:              scale_of = 32'd131071;
      FMT_INT20S:              scale_of = 32'd524287;
      default:                 scale_of = 32'd0;
    endcase
  endfunction

  function automatic logic [ByteCntWidth-1:0] bytes_of(input logic [FmtWidth-1:0] fmt);
    case (fmt)
      FMT_INT16:  bytes_of = 3'd2;
      FMT_INT24P: bytes_of = 3'd3;
      default:    bytes_of = 3'd4;
    endcase
  endfunction
endpackage

### hdl/f2p_stream_if.sv
interface f2p_stream_if #(parameter int unsigned Width = 32);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/f2p_cfg_if.sv
interface f2p_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [f2p_pkg::CfgIdxWidth-1:0]      index;
  logic [f2p_pkg::CfgDataWidth-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/f2p_convert.sv
// Float to scaled integer: the product of the 24-bit mantissa and the scale
// is shifted right by the exponent distance, then the sign is applied.
module f2p_convert (
  input  logic [31:0]                   bits_i,
  input  logic [f2p_pkg::FmtWidth-1:0]  fmt_i,
  output logic [31:0]                   word_o
);
  logic        sign;
  logic [7:0]  expo;
  logic [22:0] frac;
  logic [23:0] mant;
  logic [31:0] scale;
  logic [55:0] prod;
  logic [7:0]  shift;
  logic [55:0] shifted;
  logic [31:0] mag;

  always_comb begin
    sign    = bits_i[31];
    expo    = bits_i[30:23];
    frac    = bits_i[22:0];
    scale   = f2p_pkg::scale_of(fmt_i);
    mant    = (expo != 8'd0) ? {1'b1, frac} : {1'b0, frac};
    shift   = (expo != 8'd0) ? (8'd150 - expo) : 8'd149;
    prod    = {8'd0, mant} * {24'd0, scale};
    shifted = (shift > 8'd55) ? 56'd0 : (prod >> shift);
    if (expo >= 8'd127) begin
      mag = scale;
    end else begin
      mag = shifted[31:0];
    end
    if (fmt_i == f2p_pkg::FMT_FLOAT32) begin
      word_o = bits_i;
    end else if (expo == f2p_pkg::ExpAllOnes && frac != 23'd0) begin
      word_o = 32'd0;
    end else begin
      word_o = sign ? (32'd0 - mag) : mag;
    end
  end
endmodule

### hdl/float_to_pcm_sample_converter_core.sv
// Float-to-PCM sample converter.
// The input channel carries one IEEE-754 single-precision sample per
// transaction, interleaved by channel. Each sample is converted according to
// the 3-bit format code of its channel and leaves on the output channel with
// its byte count, channel index and frame and buffer end flags.
// The configuration channel writes channel_count (index 0), channel_formats
// (index 1) and buffer_frames (index 2); other indexes are ignored. Writes are
// always accepted and should be made only while the block is idle.
// A result is valid in the cycle after its input transaction. Throughput is
// one sample per cycle unless the receiver stalls; the path is one 24x32
// multiply and a shift between the input handshake and the result register.
// The result register moves whenever it is empty or being taken, so a stalled
// receiver holds the result and pushes back on the input with no sample lost.
// Reset clears the counters, restores the register defaults (two channels,
// all float32, 512 frames) and empties the result register.
`include "float_to_pcm_sample_converter_core_assert.svh"
module float_to_pcm_sample_converter_core #(
  parameter int unsigned MAX_CHAN = f2p_pkg::DefaultMaxChannels
) (
  input logic clk_i,
  input logic rst_ni,
  f2p_stream_if.sink   in_i,
  f2p_stream_if.source out_o,
  f2p_cfg_if.sink      cfg_i
);
  localparam int unsigned ChanLimit = (MAX_CHAN < 8) ? MAX_CHAN : 8;

  logic [f2p_pkg::ChanCountWidth-1:0] chan_count_q;
  logic [23:0]                        formats_q;
  logic [f2p_pkg::FramesWidth-1:0]    frames_q;
  logic [f2p_pkg::ChanIdxWidth-1:0]   chan_q, chan_d;
  logic [f2p_pkg::FrameCntWidth-1:0]  frame_q, frame_d;
  logic                               valid_q;
  f2p_pkg::result_t                   res_q, res_d;
  f2p_pkg::pos_t                      pos;

  logic                               in_fire;
  logic [f2p_pkg::FmtWidth-1:0]       fmt;
  logic [f2p_pkg::ChanCountWidth-1:0] chans;
  logic [f2p_pkg::FramesWidth-1:0]    frames;
  logic [31:0]                        word;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = valid_q;
  assign out_o.data  = res_q;

  always_comb begin
    fmt = formats_q[3*chan_q +: 3];
    if (chan_count_q == '0) begin
      chans = 4'd1;
    end else if (chan_count_q > 4'(ChanLimit)) begin
      chans = 4'(ChanLimit);
    end else begin
      chans = chan_count_q;
    end
    if (frames_q == '0) begin
      frames = 14'd1;
    end else if (frames_q > f2p_pkg::FrameLimit) begin
      frames = f2p_pkg::FrameLimit;
    end else begin
      frames = frames_q;
    end
    pos.channel_index  = chan_q;
    pos.last_of_frame  = ({1'b0, chan_q} + 4'd1) >= chans;
    pos.last_of_buffer = pos.last_of_frame && (({1'b0, frame_q} + 14'd1) >= frames);
    if (pos.last_of_frame) begin
      chan_d  = '0;
      frame_d = pos.last_of_buffer ? '0 : (frame_q + 13'd1);
    end else begin
      chan_d  = chan_q + 3'd1;
      frame_d = frame_q;
    end
    res_d.sample_word    = word;
    res_d.byte_count     = f2p_pkg::bytes_of(fmt);
    res_d.channel_index  = pos.channel_index;
    res_d.last_of_frame  = pos.last_of_frame;
    res_d.last_of_buffer = pos.last_of_buffer;
  end

  f2p_convert u_convert (
    .bits_i (in_i.data),
    .fmt_i  (fmt),
    .word_o (word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= 4'd2;
      formats_q    <= '0;
      frames_q     <= 14'd512;
      chan_q       <= '0;
      frame_q      <= '0;
      valid_q      <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          f2p_pkg::CFG_CHANNEL_COUNT:   chan_count_q <= cfg_i.data[3:0];
          f2p_pkg::CFG_CHANNEL_FORMATS: formats_q    <= cfg_i.data[23:0];
          f2p_pkg::CFG_BUFFER_FRAMES:   frames_q     <= cfg_i.data[13:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        chan_q  <= chan_d;
        frame_q <= frame_d;
      end
      if (in_i.ready) begin
        valid_q <= in_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  `F2P_ASSERT(a_hold_on_stall, clk_i, rst_ni, (valid_q && !out_o.ready) |=> (valid_q && $stable(res_q)), "result changed while stalled")
  `F2P_ASSERT(a_fill, clk_i, rst_ni, in_fire |=> valid_q, "accepted sample produced no result")
  `F2P_ASSERT_NEVER(a_chan_range, clk_i, rst_ni, ({1'b0, chan_q} >= 4'(ChanLimit)) && in_fire && !pos.last_of_frame, "channel counter past limit without wrap")
endmodule
